// ===== hdl/fpa_pkg.sv =====
// Package for the Q24.8 fixed-point ALU: operation codes, the classified
// item handed from front to back, and default sizes. No dependencies.
`default_nettype none
package fpa_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [3:0] {
        KIND_ADD    = 4'd0,
        KIND_SUB    = 4'd1,
        KIND_MUL    = 4'd2,
        KIND_DIV    = 4'd3,
        KIND_MIN    = 4'd4,
        KIND_MAX    = 4'd5,
        KIND_CMP    = 4'd6,
        KIND_INC    = 4'd7,
        KIND_DEC    = 4'd8,
        KIND_TO_INT = 4'd9
    } kind_t;

    // Everything but the dividend, whose width follows FRAC_BITS
    typedef struct packed {
        logic        is_div;
        logic        neg;
        logic [31:0] dsr;
        logic [31:0] res;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        dz;
    } fpa_item_t;

endpackage
`default_nettype wire

// ===== hdl/fpa_front.sv =====
// Front end: decodes one beat, computes every result but the quotient and
// prepares the divider operands. Depends on fpa_pkg.
`default_nettype none
module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                  [3:0]            kind,
    input  logic signed           [31:0]           a_raw,
    input  logic signed           [31:0]           b_raw,
    output fpa_pkg::fpa_item_t                     item,
    output logic                  [32+FRAC_BITS-1:0] dvd
);
    import fpa_pkg::*;

    logic signed [63:0] prod;
    logic        [31:0] a_mag;
    logic        [31:0] b_mag;
    logic               b_zero;

    assign prod   = a_raw * b_raw;
    assign a_mag  = a_raw[31] ? (~a_raw + 32'd1) : a_raw;
    assign b_mag  = b_raw[31] ? (~b_raw + 32'd1) : b_raw;
    assign b_zero = (b_raw == 32'sd0);
    assign dvd    = {a_mag, {FRAC_BITS{1'b0}}};

    always_comb
    begin
        item        = '0;
        item.gt     = (a_raw > b_raw);
        item.lt     = (a_raw < b_raw);
        item.eq     = (a_raw == b_raw);
        item.neg    = a_raw[31] ^ b_raw[31];
        item.dsr    = b_mag;
        unique case (kind_t'(kind))
            KIND_ADD:    item.res = a_raw + b_raw;
            KIND_SUB:    item.res = a_raw - b_raw;
            KIND_MUL:    item.res = prod[FRAC_BITS+31:FRAC_BITS];
            KIND_DIV:
            begin
                item.is_div = ~b_zero;
                item.dz     = b_zero;
            end
            KIND_MIN:    item.res = (a_raw <= b_raw) ? a_raw : b_raw;
            KIND_MAX:    item.res = (a_raw >= b_raw) ? a_raw : b_raw;
            KIND_CMP:    item.res = '0;
            KIND_INC:    item.res = a_raw + 32'sd1;
            KIND_DEC:    item.res = a_raw - 32'sd1;
            KIND_TO_INT: item.res = a_raw >>> FRAC_BITS;
            default:     item.res = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/fpa_queue.sv =====
// Short queue between front and back so either side may stall.
// Depends on fpa_pkg for its depth.
`default_nettype none
module fpa_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              q_full,
    output logic              q_empty
);
    import fpa_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [DATA_W-1:0] mem_reg [0:QUEUE_DEPTH-1];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]       count_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign q_full  = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            count_reg <= count_reg + (AW+1)'(wr_en) - (AW+1)'(rd_en);
        end
    end

endmodule
`default_nettype wire

// ===== hdl/fpa_back.sv =====
// Back end: pipelined restoring divider, one quotient bit per stage, with
// every other result riding alongside; ends in the output register.
// Depends on fpa_pkg.
`default_nettype none
module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  fpa_pkg::fpa_item_t        in_item,
    input  logic [32+FRAC_BITS-1:0]   in_dvd,
    output logic                      in_take,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [31:0]        result_raw,
    output logic                      greater,
    output logic                      less,
    output logic                      equal,
    output logic                      divide_by_zero
);
    import fpa_pkg::*;

    localparam int ND = 32 + FRAC_BITS;

    logic              v_reg   [0:ND];
    fpa_item_t         it_reg  [0:ND];
    logic [ND-1:0]     dq_reg  [0:ND];
    logic [31:0]       rem_reg [0:ND];

    logic              out_v_reg;
    logic [31:0]       out_res_reg;
    logic              out_gt_reg, out_lt_reg, out_eq_reg, out_dz_reg;

    logic              adv;
    logic [31:0]       q_lo;
    logic [31:0]       q_signed;

    // Whole pipeline moves together; hold everything while the head waits
    assign adv     = ~out_v_reg | pop;
    assign in_take = adv & in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_reg[0]  <= in_item;
            dq_reg[0]  <= in_dvd;
            rem_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < ND; k++)
    begin : g_step
        logic [32:0] trial;
        logic [32:0] diff;
        logic        qbit;

        assign trial = {rem_reg[k], dq_reg[k][ND-1]};
        assign diff  = trial - {1'b0, it_reg[k].dsr};
        assign qbit  = ~diff[32];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                it_reg[k+1]  <= it_reg[k];
                dq_reg[k+1]  <= {dq_reg[k][ND-2:0], qbit};
                rem_reg[k+1] <= qbit ? diff[31:0] : trial[31:0];
            end
        end
    end

    assign q_lo     = dq_reg[ND][31:0];
    assign q_signed = it_reg[ND].neg ? (32'd0 - q_lo) : q_lo;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= v_reg[ND];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_res_reg <= it_reg[ND].is_div ? q_signed : it_reg[ND].res;
            out_gt_reg  <= it_reg[ND].gt;
            out_lt_reg  <= it_reg[ND].lt;
            out_eq_reg  <= it_reg[ND].eq;
            out_dz_reg  <= it_reg[ND].dz;
        end
    end

    assign empty          = ~out_v_reg;
    assign result_raw     = out_res_reg;
    assign greater        = out_gt_reg;
    assign less           = out_lt_reg;
    assign equal          = out_eq_reg;
    assign divide_by_zero = out_dz_reg;

endmodule
`default_nettype wire

// ===== hdl/fixed_point_alu_q24_8_top.sv =====
// Top level of the signed fixed-point ALU (Q24.8 by default).
// Depends on fpa_pkg, fpa_front, fpa_queue and fpa_back.
//
// Signed fixed-point ALU on 32-bit raw values with FRAC_BITS fractional bits.
// Push one beat (kind, a_raw, b_raw) whenever full is low; each beat yields
// exactly one result beat, in order, shown while empty is low and taken with
// pop. Add, subtract, increment and decrement wrap; multiply keeps bits
// [FRAC_BITS+31:FRAC_BITS] of the full product; divide computes
// (a_raw * 2^FRAC_BITS) / b_raw truncated toward zero, low 32 bits, and a
// zero divisor gives result 0 with divide_by_zero set. Greater, less and
// equal always report a_raw against b_raw. Throughput is one beat per
// cycle when nothing stalls. Every operation runs through an input
// register and the same divider pipeline of 32 + FRAC_BITS stages, one
// quotient bit per stage, behind a two-entry queue and ahead of the
// output register.
`default_nettype none
module fixed_point_alu_q24_8_top #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         kind,
    input  logic signed [31:0] a_raw,
    input  logic signed [31:0] b_raw,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] result_raw,
    output logic               greater,
    output logic               less,
    output logic               equal,
    output logic               divide_by_zero
);
    import fpa_pkg::*;

    localparam int ND     = 32 + FRAC_BITS;
    localparam int ITEM_W = $bits(fpa_item_t);
    localparam int DATA_W = ITEM_W + ND;

    fpa_item_t         f_item;
    logic [ND-1:0]     f_dvd;
    logic [DATA_W-1:0] q_rd_data;
    logic              q_full, q_empty, q_take;
    fpa_item_t         b_item;
    logic [ND-1:0]     b_dvd;

    // Classify the incoming beat straight into the queue
    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .kind  (kind),
        .a_raw (a_raw),
        .b_raw (b_raw),
        .item  (f_item),
        .dvd   (f_dvd)
    );

    fpa_queue #(.DATA_W(DATA_W)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push & ~q_full),
        .wr_data ({f_item, f_dvd}),
        .rd_en   (q_take),
        .rd_data (q_rd_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    assign full   = q_full;
    assign b_item = fpa_item_t'(q_rd_data[DATA_W-1:ND]);
    assign b_dvd  = q_rd_data[ND-1:0];

    // Back end pulls from the queue whenever its pipeline can advance
    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (~q_empty),
        .in_item        (b_item),
        .in_dvd         (b_dvd),
        .in_take        (q_take),
        .empty          (empty),
        .pop            (pop),
        .result_raw     (result_raw),
        .greater        (greater),
        .less           (less),
        .equal          (equal),
        .divide_by_zero (divide_by_zero)
    );

endmodule
`default_nettype wire

// ===== hdl/fpa_checker.sv =====
// Port-level checker for the fixed-point ALU and its bind to the top level.
// Depends on fixed_point_alu_q24_8_top.
`default_nettype none
module fpa_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic signed [31:0] result_raw,
    input logic               greater,
    input logic               less,
    input logic               equal,
    input logic               divide_by_zero
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result_raw))
        else $error("result changed while stalled");

    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> $onehot({greater, less, equal}))
        else $error("compare flags not exclusive");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && divide_by_zero) |-> (result_raw == 32'sd0))
        else $error("divide by zero with non-zero result");

endmodule

bind fixed_point_alu_q24_8_top fpa_checker u_fpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .result_raw     (result_raw),
    .greater        (greater),
    .less           (less),
    .equal          (equal),
    .divide_by_zero (divide_by_zero)
);
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the Q24.8 signed fixed-point ALU: a directed table, then
// random beats, each result checked against its table row or an in-bench predictor.
// Depends on fpa_pkg and fixed_point_alu_q24_8_top.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import fpa_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LATENCY = 34 + FRAC;
    localparam int N_RANDOM = 1750;
    localparam longint CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [31:0] res;
        logic               gt;
        logic               lt;
        logic               eq;
        logic               dz;
    } alu_out_t;

    // One directed row; has_exp marks rows whose answer is typed in by hand
    typedef struct {
        logic [3:0]         kind;
        logic signed [31:0] a;
        logic signed [31:0] b;
        bit                 has_exp;
        alu_out_t           exp;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [3:0]         kind = '0;
    logic signed [31:0] a_raw = '0;
    logic signed [31:0] b_raw = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] result_raw;
    logic               greater;
    logic               less;
    logic               equal;
    logic               divide_by_zero;

    alu_out_t pending_results[$];
    int       errors = 0;
    longint   cycles = 0;
    int       n_pushed = 0;
    int       n_checked = 0;
    bit       stim_done = 0;

    fixed_point_alu_q24_8_top #(.FRAC_BITS(FRAC)) dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .kind(kind),
        .a_raw(a_raw), .b_raw(b_raw), .empty(empty), .pop(pop),
        .result_raw(result_raw), .greater(greater), .less(less),
        .equal(equal), .divide_by_zero(divide_by_zero)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Work out one result of the ALU; multiply and divide in 64-bit arithmetic
    function automatic alu_out_t alu_predict(logic [3:0] k, logic signed [31:0] a,
                                             logic signed [31:0] b);
        alu_out_t o;
        logic signed [63:0] wa;
        logic signed [63:0] wb;
        logic signed [63:0] wide;
        wa = a;
        wb = b;
        o.res = '0;
        o.dz = 1'b0;
        case (k)
            KIND_ADD:    o.res = a + b;
            KIND_SUB:    o.res = a - b;
            KIND_MUL:
            begin
                wide = (wa * wb) >>> FRAC;
                o.res = wide[31:0];
            end
            KIND_DIV:
            begin
                if (b == 0)
                    o.dz = 1'b1;
                else
                begin
                    // SV signed division truncates toward zero, as wanted
                    wide = (wa <<< FRAC) / wb;
                    o.res = wide[31:0];
                end
            end
            KIND_MIN:    o.res = (a <= b) ? a : b;
            KIND_MAX:    o.res = (a >= b) ? a : b;
            KIND_INC:    o.res = a + 32'sd1;
            KIND_DEC:    o.res = a - 32'sd1;
            KIND_TO_INT: o.res = a >>> FRAC;
            default:     o.res = '0;
        endcase
        o.gt = a > b;
        o.lt = a < b;
        o.eq = a == b;
        return o;
    endfunction

    function automatic alu_out_t mk(logic signed [31:0] r, logic g, logic l,
                                    logic e, logic z);
        alu_out_t o;
        o.res = r;
        o.gt = g;
        o.lt = l;
        o.eq = e;
        o.dz = z;
        return o;
    endfunction

    function automatic logic signed [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff - $urandom_range(0, 3);
            1: return 32'sh80000000 + $urandom_range(0, 3);
            2: return $urandom_range(0, 4) - 2;
            3: return $signed($urandom_range(0, 1 << 16)) - (1 << 15);
            default: return $urandom;
        endcase
    endfunction

    // Push one beat after a random gap; the gap may be zero
    task automatic push_beat(logic [3:0] k, logic signed [31:0] a,
                             logic signed [31:0] b, bit has_exp, alu_out_t exp);
        alu_out_t p;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        // Drop push only if this beat does not follow straight away
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        kind <= k;
        a_raw <= a;
        b_raw <= b;
        // Hold the beat until the queue takes it
        do
            @(posedge clk);
        while (full);
        p = alu_predict(k, a, b);
        if (has_exp && p != exp)
        begin
            $error("table row kind %0d: predictor gives %h, table %h", k, p.res, exp.res);
            errors++;
        end
        pending_results.push_back(has_exp ? exp : p);
        n_pushed++;
    endtask

    // Stimulus: directed table, then random beats
    initial
    begin
        row_t rows[$];
        alu_out_t none;
        logic [3:0] k;
        none = mk(0, 0, 0, 0, 0);
        rows = '{
            '{KIND_ADD, 32'sh7fffffff, 32'sd1, 1, mk(32'sh80000000, 1, 0, 0, 0)},
            '{KIND_SUB, 32'sh80000000, 32'sd1, 1, mk(32'sh7fffffff, 0, 1, 0, 0)},
            '{KIND_MUL, 32'sd512, 32'sd768, 1, mk(32'sd1536, 0, 1, 0, 0)},
            '{KIND_MUL, 32'sh80000000, 32'sh80000000, 0, none},
            '{KIND_MUL, -32'sd1, 32'sd1, 1, mk(-32'sd1, 0, 1, 0, 0)},
            '{KIND_DIV, 32'sd256, 32'sd0, 1, mk(0, 1, 0, 0, 1)},
            '{KIND_DIV, 32'sd0, 32'sd0, 1, mk(0, 0, 0, 1, 1)},
            '{KIND_DIV, 32'sh80000000, -32'sd1, 0, none},
            '{KIND_DIV, 32'sh7fffffff, 32'sd1, 0, none},
            '{KIND_DIV, -32'sd768, 32'sd512, 0, none},
            '{KIND_MIN, 32'sh80000000, 32'sh7fffffff, 1, mk(32'sh80000000, 0, 1, 0, 0)},
            '{KIND_MIN, 32'sd5, 32'sd5, 1, mk(32'sd5, 0, 0, 1, 0)},
            '{KIND_MAX, 32'sh80000000, 32'sh7fffffff, 1, mk(32'sh7fffffff, 0, 1, 0, 0)},
            '{KIND_CMP, 32'sd3, 32'sd2, 1, mk(0, 1, 0, 0, 0)},
            '{KIND_INC, 32'sh7fffffff, 32'sd0, 1, mk(32'sh80000000, 1, 0, 0, 0)},
            '{KIND_DEC, 32'sh80000000, 32'sd0, 1, mk(32'sh7fffffff, 0, 1, 0, 0)},
            '{KIND_TO_INT, -32'sd1, -32'sd1, 1, mk(-32'sd1, 0, 0, 1, 0)},
            '{KIND_TO_INT, 32'sh7fffffff, 32'sd0, 1, mk(32'sh007fffff, 1, 0, 0, 0)},
            '{4'd10, 32'sd1, 32'sd2, 1, mk(0, 0, 1, 0, 0)},
            '{4'd15, -32'sd1, -32'sd1, 1, mk(0, 0, 0, 1, 0)}
        };
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            push_beat(rows[i].kind, rows[i].a, rows[i].b, rows[i].has_exp, rows[i].exp);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            // Mostly real operations, a few unknown codes
            k = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
            push_beat(k, rand_operand(), rand_operand(), 0, none);
        end
        push <= 1'b0;
        stim_done = 1;
    end

    // Result side: draw a stall per result, with stretches of none at all
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        alu_out_t e;
        cycles <= cycles + 1;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected: %h", result_raw);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                n_checked++;
                if (result_raw !== e.res)
                begin
                    $error("result_raw: expected %h, got %h", e.res, result_raw);
                    errors++;
                end
                if (greater !== e.gt)
                begin
                    $error("greater: expected %b, got %b", e.gt, greater);
                    errors++;
                end
                if (less !== e.lt)
                begin
                    $error("less: expected %b, got %b", e.lt, less);
                    errors++;
                end
                if (equal !== e.eq)
                begin
                    $error("equal: expected %b, got %b", e.eq, equal);
                    errors++;
                end
                if (divide_by_zero !== e.dz)
                begin
                    $error("divide_by_zero: expected %b, got %b", e.dz, divide_by_zero);
                    errors++;
                end
            end
        end
    end

    // End of run: drain, let the pipeline settle, then report
    initial
    begin
        wait (stim_done && pending_results.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        $display("Covered %0d beats across all ten operations and unknown codes,",
                 n_pushed);
        $display("%0d results checked, %0d mismatches.", n_checked, errors);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog against a hung handshake
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles.", cycles);
        $display("tb failed");
        $finish;
    end
endmodule
`default_nettype wire
